FILE: src/cttm_pkg.sv
// Shared types, constants and codes of the connector thermal trip monitor.
package cttm_pkg;

    localparam int SENSOR_COUNT_DEF = 2;
    localparam int QUEUE_DEPTH      = 2;

    localparam int TEMP_W  = 19;
    localparam int DIFF_W  = TEMP_W + 1;
    localparam int GAP_W   = 16;
    localparam int BOARD_W = 9;
    localparam int RLIM_W  = 29;
    localparam int RATE_W  = 30;
    localparam int NUM_W   = 29;
    localparam int CFG_W   = 29;
    localparam int CIDX_W  = 3;

    localparam logic signed [TEMP_W-1:0] DEFLT_MILLI  = 19'sd25000;
    localparam logic signed [TEMP_W-1:0] MARGIN_MILLI = 19'sd1000;
    localparam logic signed [TEMP_W-1:0] DEFLT_DEG    = 19'sd25;
    localparam logic signed [TEMP_W-1:0] MARGIN_DEG   = 19'sd1;
    localparam logic [9:0]               MS_PER_S     = 10'd1000;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MILLI_MODE   = 3'd0,
        CFG_TRIP_TEMP    = 3'd1,
        CFG_RECOVER_TEMP = 3'd2,
        CFG_BOARD_COMBO  = 3'd3,
        CFG_RATE_COMBO   = 3'd4,
        CFG_BOARD_LIMIT  = 3'd5,
        CFG_RATE_LIMIT   = 3'd6,
        CFG_PROT_DISABLE = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                      milli_mode;
        logic signed [TEMP_W-1:0]  trip_temp;
        logic signed [TEMP_W-1:0]  recover_temp;
        logic signed [TEMP_W-1:0]  board_combo_temp;
        logic signed [TEMP_W-1:0]  rate_combo_temp;
        logic signed [BOARD_W-1:0] board_limit;
        logic [RLIM_W-1:0]         rate_limit;
        logic                      protect_disable;
    } t_cfg;

    typedef enum logic [1:0] {
        K_SEED,
        K_HOLD,
        K_DIVIDE
    } t_kind;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_TRIPPED   = 2'd1,
        EV_RECOVERED = 2'd2,
        EV_ALARM_CLR = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } t_state;

    // One classified sample, as it travels from the front to the back.
    typedef struct packed {
        t_kind                     kind;
        logic signed [DIFF_W-1:0]  diff0;
        logic signed [DIFF_W-1:0]  diff1;
        logic [GAP_W-1:0]          gap;
        logic                      hot;
        logic signed [TEMP_W-1:0]  temp;
        logic signed [BOARD_W-1:0] board;
        logic                      online;
        logic                      cable;
        logic                      otg;
    } t_work;

endpackage

FILE: src/cttm_front.sv
// Front end: accepts samples, keeps the previous temperatures and classifies each sample.
module cttm_front #(
    parameter int SENSOR_COUNT = cttm_pkg::SENSOR_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [cttm_pkg::TEMP_W-1:0]  i_temp_a,
    input  logic signed [cttm_pkg::TEMP_W-1:0]  i_temp_b,
    input  logic [cttm_pkg::GAP_W-1:0]          i_gap_ms,
    input  logic signed [cttm_pkg::BOARD_W-1:0] i_board_temp,
    input  logic                                i_charger_online,
    input  logic                                i_cable_present,
    input  logic                                i_otg_present,
    input  logic                                i_milli_mode,
    input  logic                                i_full,
    output logic                                o_push,
    output cttm_pkg::t_work                     o_word
);

    logic                               r_seeded;
    logic signed [cttm_pkg::TEMP_W-1:0] r_prev [2];

    logic signed [cttm_pkg::TEMP_W-1:0] deflt;
    logic signed [cttm_pkg::TEMP_W-1:0] margin;
    logic signed [cttm_pkg::TEMP_W-1:0] t0;
    logic signed [cttm_pkg::TEMP_W-1:0] t1;
    logic signed [cttm_pkg::TEMP_W-1:0] hot_t;
    logic                               hot;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    assign deflt  = i_milli_mode ? cttm_pkg::DEFLT_MILLI : cttm_pkg::DEFLT_DEG;
    assign margin = i_milli_mode ? cttm_pkg::MARGIN_MILLI : cttm_pkg::MARGIN_DEG;
    assign t0     = i_temp_a;
    assign t1     = (SENSOR_COUNT >= 2) ? i_temp_b : deflt;
    assign hot    = (t1 > t0);
    assign hot_t  = hot ? t1 : t0;

    always_comb begin
        if (!r_seeded) begin
            o_word.kind = cttm_pkg::K_SEED;
        end else if (i_gap_ms != '0) begin
            o_word.kind = cttm_pkg::K_DIVIDE;
        end else begin
            o_word.kind = cttm_pkg::K_HOLD;
        end
        o_word.diff0  = {t0[cttm_pkg::TEMP_W-1], t0} - {r_prev[0][cttm_pkg::TEMP_W-1], r_prev[0]};
        o_word.diff1  = {t1[cttm_pkg::TEMP_W-1], t1} - {r_prev[1][cttm_pkg::TEMP_W-1], r_prev[1]};
        o_word.gap    = i_gap_ms;
        o_word.hot    = hot;
        // Compare in one extra bit so that default plus margin cannot wrap.
        o_word.temp   = ($signed({hot_t[cttm_pkg::TEMP_W-1], hot_t}) <
                         ($signed({deflt[cttm_pkg::TEMP_W-1], deflt}) +
                          $signed({margin[cttm_pkg::TEMP_W-1], margin}))) ? deflt : hot_t;
        o_word.board  = i_board_temp;
        o_word.online = i_charger_online;
        o_word.cable  = i_cable_present;
        o_word.otg    = i_otg_present;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
            r_prev[0] <= '0;
            r_prev[1] <= '0;
        end else if (o_push && (!r_seeded || i_gap_ms != '0)) begin
            r_seeded <= 1'b1;
            r_prev[0] <= t0;
            r_prev[1] <= t1;
        end
    end

endmodule

FILE: src/cttm_queue.sv
// Short queue of classified samples between the front end and the back end.
module cttm_queue #(
    parameter int DEPTH = cttm_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cttm_pkg::t_work i_word,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output cttm_pkg::t_work o_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cttm_pkg::t_work   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_word  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/cttm_back.sv
// Back end: serial rate divider shared by both channels, trip decision and output register.
module cttm_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cttm_pkg::t_cfg                      i_cfg,
    input  logic                                i_empty,
    input  cttm_pkg::t_work                     i_word,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_tripped,
    output logic                                o_switch_open,
    output logic                                o_alarm,
    output logic [1:0]                          o_event_code,
    output logic signed [cttm_pkg::TEMP_W-1:0]  o_report_temp,
    output logic signed [cttm_pkg::RATE_W-1:0]  o_report_rate,
    output logic                                o_fast_poll
);

    localparam int CNT_W = $clog2(cttm_pkg::NUM_W);

    cttm_pkg::t_state                   r_state;
    cttm_pkg::t_state                   n_state;
    cttm_pkg::t_work                    r_word;
    logic                               r_ch;
    logic                               r_neg;
    logic [cttm_pkg::NUM_W-1:0]         r_num;
    logic [cttm_pkg::GAP_W-1:0]         r_rem;
    logic [CNT_W-1:0]                   r_cnt;
    logic signed [cttm_pkg::RATE_W-1:0] r_rate [2];
    logic                               r_trip;
    logic                               r_alarm;
    logic                               r_out_valid;

    logic                               out_free;
    logic                               fire;
    logic                               div_last;
    logic signed [cttm_pkg::DIFF_W-1:0] diff;
    logic [cttm_pkg::DIFF_W-1:0]        mag;
    logic [cttm_pkg::NUM_W-1:0]         product;
    logic [cttm_pkg::GAP_W:0]           rem_sh;
    logic                               ge;
    logic [cttm_pkg::GAP_W-1:0]         n_rem;
    logic [cttm_pkg::NUM_W-1:0]         n_num;
    logic signed [cttm_pkg::RATE_W-1:0] quot;
    logic signed [cttm_pkg::RATE_W-1:0] rate;
    logic signed [cttm_pkg::RATE_W-1:0] rlim;
    logic                               cond;
    logic                               trip_now;
    logic                               recover;
    logic                               alarm_set;
    logic                               alarm_clr;
    cttm_pkg::t_event                   ev;

    function automatic logic [cttm_pkg::NUM_W-1:0] NUM_W_MUL(
        input logic [cttm_pkg::TEMP_W-1:0] m
    );
        logic [cttm_pkg::NUM_W-1:0] wide;
        wide = {{(cttm_pkg::NUM_W - cttm_pkg::TEMP_W){1'b0}}, m} *
               {{(cttm_pkg::NUM_W - 10){1'b0}}, cttm_pkg::MS_PER_S};
        return wide;
    endfunction

    assign out_free = !r_out_valid || !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cttm_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_word.kind == cttm_pkg::K_DIVIDE) ? cttm_pkg::ST_LOAD
                                                                  : cttm_pkg::ST_FINISH;
                end
            end
            cttm_pkg::ST_LOAD: begin
                n_state = cttm_pkg::ST_DIV;
            end
            cttm_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = r_ch ? cttm_pkg::ST_FINISH : cttm_pkg::ST_LOAD;
                end
            end
            cttm_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = cttm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cttm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_pop    = 1'b0;
        fire     = 1'b0;
        div_last = 1'b0;
        case (r_state)
            cttm_pkg::ST_IDLE:   o_pop    = !i_empty;
            cttm_pkg::ST_DIV:    div_last = (r_cnt == '0);
            cttm_pkg::ST_FINISH: fire     = out_free;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // Numerator magnitude for the channel being loaded: |diff| * 1000 fits in NUM_W bits.
    assign diff    = r_ch ? r_word.diff1 : r_word.diff0;
    assign mag     = diff[cttm_pkg::DIFF_W-1] ? (-diff) : diff;
    assign product = NUM_W_MUL(mag[cttm_pkg::TEMP_W-1:0]);

    // One restoring division step per cycle.
    assign rem_sh = {r_rem, r_num[cttm_pkg::NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_word.gap});
    assign n_rem  = ge ? cttm_pkg::GAP_W'(rem_sh - {1'b0, r_word.gap})
                       : rem_sh[cttm_pkg::GAP_W-1:0];
    assign n_num  = {r_num[cttm_pkg::NUM_W-2:0], ge};
    assign quot   = r_neg ? -$signed({1'b0, n_num}) : $signed({1'b0, n_num});

    // Trip, recovery and alarm decision on the updated rates.
    assign rate      = r_rate[r_word.hot];
    assign rlim      = $signed({1'b0, i_cfg.rate_limit});
    assign cond      = (r_word.temp >= i_cfg.trip_temp) ||
                       ((r_word.temp >= i_cfg.board_combo_temp) &&
                        (r_word.board <= i_cfg.board_limit)) ||
                       ((r_word.temp >= i_cfg.rate_combo_temp) && (rate >= rlim));
    assign trip_now  = cond && !r_trip && !i_cfg.protect_disable &&
                       (r_word.cable || r_word.online);
    assign recover   = !trip_now && r_trip && (r_word.temp < i_cfg.recover_temp) &&
                       (rate < rlim) && !r_word.otg && !r_word.cable;
    assign alarm_set = trip_now || r_alarm;
    assign alarm_clr = alarm_set && !r_word.cable;

    always_comb begin
        if (trip_now) begin
            ev = cttm_pkg::EV_TRIPPED;
        end else if (recover) begin
            ev = cttm_pkg::EV_RECOVERED;
        end else if (alarm_clr) begin
            ev = cttm_pkg::EV_ALARM_CLR;
        end else begin
            ev = cttm_pkg::EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cttm_pkg::ST_IDLE;
            r_rate[0]   <= '0;
            r_rate[1]   <= '0;
            r_trip      <= 1'b0;
            r_alarm     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && i_word.kind == cttm_pkg::K_SEED) begin
                r_rate[0] <= '0;
                r_rate[1] <= '0;
            end
            if (div_last) begin
                r_rate[r_ch] <= quot;
            end
            if (fire) begin
                r_trip  <= trip_now ? 1'b1 : (recover ? 1'b0 : r_trip);
                r_alarm <= alarm_set && !alarm_clr;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_word;
            r_ch   <= 1'b0;
        end
        if (r_state == cttm_pkg::ST_LOAD) begin
            r_num <= product;
            r_rem <= '0;
            r_neg <= diff[cttm_pkg::DIFF_W-1];
            r_cnt <= CNT_W'(cttm_pkg::NUM_W - 1);
        end else if (r_state == cttm_pkg::ST_DIV) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
            if (div_last) begin
                r_ch <= 1'b1;
            end
        end
        if (fire) begin
            o_tripped     <= trip_now ? 1'b1 : (recover ? 1'b0 : r_trip);
            o_switch_open <= trip_now ? 1'b1 : (recover ? 1'b0 : r_trip);
            o_alarm       <= alarm_set && !alarm_clr;
            o_event_code  <= ev;
            o_report_temp <= r_word.temp;
            o_report_rate <= rate;
            o_fast_poll   <= r_word.otg || r_word.online;
        end
    end

    assign o_valid = r_out_valid;

endmodule

FILE: src/connector_thermal_trip_monitor.sv
// Top level of the connector thermal trip monitor: configuration registers and the three parts.
//
// Each accepted word carries two connector temperatures, the milliseconds since the previous
// word, a board temperature and the charger, cable and OTG flags; each one yields exactly one
// result word with the trip state, switch control, alarm flag, event code, the clamped hotter
// temperature, its rise rate per second and the poll interval select. The front end takes a
// word whenever the two-entry queue has room, so input and output stall independently. The
// back end sets the pace: a first (seeding) word or a word with a zero gap goes straight to
// the decision, while for any other word both channels' rates first go one after the other
// through one shared restoring divider that retires one quotient bit per cycle (29 bits per
// channel, each after a load step). Configuration registers are written through i_cfg_we,
// i_cfg_index and i_cfg_data and must only be changed while the block is idle.
// With SENSOR_COUNT set to 1 the second channel reads the default temperature and i_temp_b is
// ignored.
module connector_thermal_trip_monitor #(
    parameter int SENSOR_COUNT = cttm_pkg::SENSOR_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [cttm_pkg::TEMP_W-1:0]  i_temp_a,
    input  logic signed [cttm_pkg::TEMP_W-1:0]  i_temp_b,
    input  logic [cttm_pkg::GAP_W-1:0]          i_gap_ms,
    input  logic signed [cttm_pkg::BOARD_W-1:0] i_board_temp,
    input  logic                                i_charger_online,
    input  logic                                i_cable_present,
    input  logic                                i_otg_present,
    // Output channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_tripped,
    output logic                                o_switch_open,
    output logic                                o_alarm,
    output logic [1:0]                          o_event_code,
    output logic signed [cttm_pkg::TEMP_W-1:0]  o_report_temp,
    output logic signed [cttm_pkg::RATE_W-1:0]  o_report_rate,
    output logic                                o_fast_poll,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [cttm_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [cttm_pkg::CFG_W-1:0]          i_cfg_data
);

    cttm_pkg::t_cfg  r_cfg;
    cttm_pkg::t_work front_word;
    cttm_pkg::t_work queue_word;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    // Configuration registers. Each write keeps only the low bits of the data that the
    // register holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.milli_mode       <= 1'b0;
            r_cfg.trip_temp        <= 19'sd65;
            r_cfg.recover_temp     <= 19'sd55;
            r_cfg.board_combo_temp <= 19'sd60;
            r_cfg.rate_combo_temp  <= 19'sd35;
            r_cfg.board_limit      <= 9'sd50;
            r_cfg.rate_limit       <= 29'd4;
            r_cfg.protect_disable  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cttm_pkg::CFG_MILLI_MODE:   r_cfg.milli_mode       <= i_cfg_data[0];
                cttm_pkg::CFG_TRIP_TEMP:    r_cfg.trip_temp        <= i_cfg_data[18:0];
                cttm_pkg::CFG_RECOVER_TEMP: r_cfg.recover_temp     <= i_cfg_data[18:0];
                cttm_pkg::CFG_BOARD_COMBO:  r_cfg.board_combo_temp <= i_cfg_data[18:0];
                cttm_pkg::CFG_RATE_COMBO:   r_cfg.rate_combo_temp  <= i_cfg_data[18:0];
                cttm_pkg::CFG_BOARD_LIMIT:  r_cfg.board_limit      <= i_cfg_data[8:0];
                cttm_pkg::CFG_RATE_LIMIT:   r_cfg.rate_limit       <= i_cfg_data[28:0];
                cttm_pkg::CFG_PROT_DISABLE: r_cfg.protect_disable  <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // The front end seeds and tracks the previous temperatures, picks the hotter channel and
    // clamps it, so the back end only has to divide and decide.
    cttm_front #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_temp_a         (i_temp_a),
        .i_temp_b         (i_temp_b),
        .i_gap_ms         (i_gap_ms),
        .i_board_temp     (i_board_temp),
        .i_charger_online (i_charger_online),
        .i_cable_present  (i_cable_present),
        .i_otg_present    (i_otg_present),
        .i_milli_mode     (r_cfg.milli_mode),
        .i_full           (q_full),
        .o_push           (push),
        .o_word           (front_word)
    );

    cttm_queue #(
        .DEPTH (cttm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (front_word),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_word  (queue_word)
    );

    // The back end holds the rise rates and the trip and alarm flags, and drives the output
    // register directly.
    cttm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (q_empty),
        .i_word        (queue_word),
        .o_pop         (pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_tripped     (o_tripped),
        .o_switch_open (o_switch_open),
        .o_alarm       (o_alarm),
        .o_event_code  (o_event_code),
        .o_report_temp (o_report_temp),
        .o_report_rate (o_report_rate),
        .o_fast_poll   (o_fast_poll)
    );

endmodule

FILE: sim/tb_connector_thermal_trip_monitor.sv
// Self-checking testbench for the connector thermal trip monitor, with its own trip predictor.
module tb_connector_thermal_trip_monitor;
    import cttm_pkg::*;

    localparam int     SENSORS       = SENSOR_COUNT_DEF;
    localparam longint MS_PER_SECOND = 1000;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     TAIL_CYCLES   = 80;
    localparam int     HOLD_CYCLES   = 600;
    localparam int     TIMEOUT_UNITS = 12 * 600000;

    // One sample word as it is offered on the input channel.
    typedef struct packed {
        logic signed [TEMP_W-1:0]  temp_a;
        logic signed [TEMP_W-1:0]  temp_b;
        logic [GAP_W-1:0]          gap_ms;
        logic signed [BOARD_W-1:0] board_temp;
        logic                      online;
        logic                      cable;
        logic                      otg;
    } t_thermal_sample;

    // The result word that one sample is predicted to produce.
    typedef struct packed {
        logic               tripped;
        logic               switch_open;
        logic               alarm;
        t_event             ev;
        logic [TEMP_W-1:0]  temp;
        logic [RATE_W-1:0]  rate;
        logic               fast;
    } t_trip_response;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [TEMP_W-1:0]  i_temp_a = '0;
    logic signed [TEMP_W-1:0]  i_temp_b = '0;
    logic [GAP_W-1:0]          i_gap_ms = '0;
    logic signed [BOARD_W-1:0] i_board_temp = '0;
    logic                      i_charger_online = 1'b0;
    logic                      i_cable_present = 1'b0;
    logic                      i_otg_present = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic                      o_tripped;
    logic                      o_switch_open;
    logic                      o_alarm;
    logic [1:0]                o_event_code;
    logic signed [TEMP_W-1:0]  o_report_temp;
    logic signed [RATE_W-1:0]  o_report_rate;
    logic                      o_fast_poll;
    logic                      i_cfg_we = 1'b0;
    t_cfg_idx                  i_cfg_index = CFG_MILLI_MODE;
    logic [CFG_W-1:0]          i_cfg_data = '0;

    // Predictor state: configuration shadow and the per-channel history.
    t_cfg                      shadow_cfg;
    logic signed [TEMP_W-1:0]  prior_temp [2];
    logic signed [RATE_W-1:0]  rise_rate [2];
    bit                        seeded_flag;
    bit                        trip_state;
    bit                        alarm_state;

    t_trip_response            pending_responses [$];
    int unsigned               error_count = 0;
    int unsigned               send_idle_pct = 0;
    int unsigned               recv_stall_pct = 0;
    int unsigned               out_hold_cycles = 0;
    longint                    walk_temp = 40;

    connector_thermal_trip_monitor #(
        .SENSOR_COUNT(SENSORS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_temp_a         (i_temp_a),
        .i_temp_b         (i_temp_b),
        .i_gap_ms         (i_gap_ms),
        .i_board_temp     (i_board_temp),
        .i_charger_online (i_charger_online),
        .i_cable_present  (i_cable_present),
        .i_otg_present    (i_otg_present),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_tripped        (o_tripped),
        .o_switch_open    (o_switch_open),
        .o_alarm          (o_alarm),
        .o_event_code     (o_event_code),
        .o_report_temp    (o_report_temp),
        .o_report_rate    (o_report_rate),
        .o_fast_poll      (o_fast_poll),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("%0t: run did not complete in time", $time);
        $display("TB_ERROR");
        $finish;
    end

    // Receiver side: a long hold-off when one is requested, random stalls otherwise.
    always @(posedge i_clk) begin
        if (out_hold_cycles != 0) begin
            i_out_stall <= 1'b1;
            out_hold_cycles <= out_hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic t_cfg make_settings(input longint milli, input longint trip,
                                           input longint recover, input longint board_combo,
                                           input longint rate_combo, input longint board_lim,
                                           input longint rate_lim, input longint disable_trip);
        t_cfg s;
        s.milli_mode       = milli[0];
        s.trip_temp        = trip[TEMP_W-1:0];
        s.recover_temp     = recover[TEMP_W-1:0];
        s.board_combo_temp = board_combo[TEMP_W-1:0];
        s.rate_combo_temp  = rate_combo[TEMP_W-1:0];
        s.board_limit      = board_lim[BOARD_W-1:0];
        s.rate_limit       = rate_lim[RLIM_W-1:0];
        s.protect_disable  = disable_trip[0];
        return s;
    endfunction

    function automatic t_cfg reset_settings();
        return make_settings(0, 65, 55, 60, 35, 50, 4, 0);
    endfunction

    function automatic t_thermal_sample sample(input longint a, input longint b,
                                               input longint gap, input longint board,
                                               input bit online, input bit cable,
                                               input bit otg);
        t_thermal_sample s;
        s.temp_a     = a[TEMP_W-1:0];
        s.temp_b     = b[TEMP_W-1:0];
        s.gap_ms     = gap[GAP_W-1:0];
        s.board_temp = board[BOARD_W-1:0];
        s.online     = online;
        s.cable      = cable;
        s.otg        = otg;
        return s;
    endfunction

    // Computes the result word of one accepted sample and advances the predictor state.
    function automatic t_trip_response predict_trip_response(input t_thermal_sample s);
        t_trip_response r;
        longint deflt;
        longint margin;
        longint gap;
        longint board;
        longint rate_lim;
        longint chan [2];
        longint temp;
        longint rate;
        int     hot;
        bit     cond;
        t_event ev;
        if (shadow_cfg.milli_mode) begin
            deflt  = DEFLT_MILLI;
            margin = MARGIN_MILLI;
        end else begin
            deflt  = DEFLT_DEG;
            margin = MARGIN_DEG;
        end
        gap      = s.gap_ms;
        board    = $signed(s.board_temp);
        rate_lim = shadow_cfg.rate_limit;
        chan[0]  = $signed(s.temp_a);
        if (SENSORS >= 2)
            chan[1] = $signed(s.temp_b);
        else
            chan[1] = deflt;

        // The first sample after reset only seeds the history; a zero gap leaves it alone.
        if (!seeded_flag) begin
            for (int i = 0; i < 2; i++) begin
                prior_temp[i] = chan[i];
                rise_rate[i]  = '0;
            end
            seeded_flag = 1'b1;
        end else if (gap >= 1) begin
            for (int i = 0; i < 2; i++) begin
                rise_rate[i]  = (chan[i] - longint'(prior_temp[i])) * MS_PER_SECOND / gap;
                prior_temp[i] = chan[i];
            end
        end

        hot  = (chan[1] > chan[0]) ? 1 : 0;
        temp = chan[hot];
        rate = rise_rate[hot];
        if (temp < deflt + margin)
            temp = deflt;

        cond = (temp >= $signed(shadow_cfg.trip_temp)) ||
               (temp >= $signed(shadow_cfg.board_combo_temp) &&
                board <= $signed(shadow_cfg.board_limit)) ||
               (temp >= $signed(shadow_cfg.rate_combo_temp) && rate >= rate_lim);

        ev = EV_NONE;
        if (cond && !trip_state && !shadow_cfg.protect_disable && (s.cable || s.online)) begin
            trip_state  = 1'b1;
            alarm_state = 1'b1;
            ev = EV_TRIPPED;
        end else if (trip_state && temp < $signed(shadow_cfg.recover_temp) &&
                     rate < rate_lim && !s.otg && !s.cable) begin
            trip_state = 1'b0;
            ev = EV_RECOVERED;
        end
        // The alarm drops once the plug is gone, even in the sample that tripped.
        if (alarm_state && !s.cable) begin
            alarm_state = 1'b0;
            if (ev == EV_NONE)
                ev = EV_ALARM_CLR;
        end

        r.tripped     = trip_state;
        r.switch_open = trip_state;
        r.alarm       = alarm_state;
        r.ev          = ev;
        r.temp        = temp[TEMP_W-1:0];
        r.rate        = rate[RATE_W-1:0];
        r.fast        = s.otg | s.online;
        return r;
    endfunction

    // Mostly a temperature walk around the thresholds with realistic gaps; some raw noise.
    function automatic t_thermal_sample random_sample();
        t_thermal_sample s;
        longint unit_scale;
        longint board;
        unit_scale = shadow_cfg.milli_mode ? 1000 : 1;
        if ($urandom_range(99) < 12) begin
            s.temp_a     = TEMP_W'($urandom);
            s.temp_b     = TEMP_W'($urandom);
            s.gap_ms     = GAP_W'($urandom);
            s.board_temp = BOARD_W'($urandom);
            s.online     = 1'($urandom);
            s.cable      = 1'($urandom);
            s.otg        = 1'($urandom);
            return s;
        end
        walk_temp += (longint'($urandom_range(24)) - 12) * unit_scale;
        if (walk_temp < -10 * unit_scale || walk_temp > 100 * unit_scale)
            walk_temp = longint'($urandom_range(20, 80)) * unit_scale;
        s.temp_a = walk_temp[TEMP_W-1:0];
        s.temp_b = TEMP_W'(walk_temp + (longint'($urandom_range(16)) - 8) * unit_scale);
        case ($urandom_range(9))
            0:       s.gap_ms = '0;
            1:       s.gap_ms = GAP_W'($urandom_range(1, 20));
            2:       s.gap_ms = '1;
            default: s.gap_ms = GAP_W'($urandom_range(500, 2000));
        endcase
        if ($urandom_range(9) == 0)
            board = longint'($urandom_range(300)) - 100;
        else
            board = longint'($urandom_range(80)) - 10;
        s.board_temp = board[BOARD_W-1:0];
        s.online     = 1'($urandom);
        s.cable      = 1'($urandom);
        s.otg        = 1'($urandom);
        return s;
    endfunction

    // Offers one word, keeps it steady while stalled, and records its expected result
    // on the falling edge before the edge that takes it.
    task automatic send_sample(input t_thermal_sample s);
        bit stalled;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            if ($urandom_range(15) == 0)
                repeat ($urandom_range(1, 80)) @(posedge i_clk);
            else
                @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_temp_a         <= s.temp_a;
        i_temp_b         <= s.temp_b;
        i_gap_ms         <= s.gap_ms;
        i_board_temp     <= s.board_temp;
        i_charger_online <= s.online;
        i_cable_present  <= s.cable;
        i_otg_present    <= s.otg;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            if (!stalled)
                pending_responses.push_back(predict_trip_response(s));
            @(posedge i_clk);
        end while (stalled);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_sample(random_sample());
    endtask

    // Withdraws the input and waits until every expected result has been taken.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg s);
        t_cfg_idx idx;
        wait_for_drain();
        for (int k = 0; k < (1 << CIDX_W); k++) begin
            idx = t_cfg_idx'(k);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            case (idx)
                CFG_MILLI_MODE:   i_cfg_data <= CFG_W'(s.milli_mode);
                CFG_TRIP_TEMP:    i_cfg_data <= CFG_W'(s.trip_temp);
                CFG_RECOVER_TEMP: i_cfg_data <= CFG_W'(s.recover_temp);
                CFG_BOARD_COMBO:  i_cfg_data <= CFG_W'(s.board_combo_temp);
                CFG_RATE_COMBO:   i_cfg_data <= CFG_W'(s.rate_combo_temp);
                CFG_BOARD_LIMIT:  i_cfg_data <= CFG_W'(s.board_limit);
                CFG_RATE_LIMIT:   i_cfg_data <= CFG_W'(s.rate_limit);
                CFG_PROT_DISABLE: i_cfg_data <= CFG_W'(s.protect_disable);
                default:          i_cfg_data <= '0;
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        shadow_cfg = s;
    endtask

    task automatic select_idling(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
    endtask

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Every result word taken by the receiver is compared with the oldest expectation.
    always @(negedge i_clk) begin
        t_trip_response want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected result word, temp %0d rate %0d", $time,
                         o_report_temp, o_report_rate);
                error_count++;
            end else begin
                want = pending_responses.pop_front();
                check_field("tripped", want.tripped, o_tripped);
                check_field("switch_open", want.switch_open, o_switch_open);
                check_field("alarm", want.alarm, o_alarm);
                check_field("event_code", want.ev, o_event_code);
                check_field("report_temp", $signed(want.temp), o_report_temp);
                check_field("report_rate", $signed(want.rate), o_report_rate);
                check_field("fast_poll", want.fast, o_fast_poll);
            end
        end
    end

    // Hand-picked samples at the reset settings: seeding, zero gap, hotter-channel choice,
    // the clamp, each trip condition, blocked and granted recovery, and field extremes.
    task automatic test_directed();
        select_idling(0);
        send_sample(sample(30, 20, 65535, -100, 0, 0, 0));       // seeds, gap ignored
        send_sample(sample(70, -100000, 0, 200, 0, 1, 0));       // zero gap, plain trip
        send_sample(sample(40, 40, 1000, 0, 0, 1, 0));           // tie goes to channel a
        send_sample(sample(20, 25, 1000, 0, 1, 0, 1));           // clamp; OTG holds the trip
        send_sample(sample(26, -5, 500, 0, 0, 0, 0));            // fast rise blocks recovery
        send_sample(sample(26, 0, 1000, 0, 0, 0, 0));            // recovers
        send_sample(sample(100, 0, 1000, 0, 1, 0, 0));           // trip and alarm clear at once
        send_sample(sample(30, 0, 1000, 0, 0, 0, 0));
        send_sample(sample(60, 0, 65535, 50, 1, 1, 0));          // board combination trip
        send_sample(sample(40, 0, 1000, 0, 0, 0, 0));
        send_sample(sample(60, 0, 65535, 51, 1, 1, 0));          // board just too warm
        send_sample(sample(30, 0, 1000, 0, 0, 1, 0));
        send_sample(sample(35, 0, 1000, 0, 0, 1, 0));            // rate combination trip
        send_sample(sample(35, 0, 0, 0, 0, 0, 0));               // kept rate blocks recovery
        send_sample(sample(35, 0, 1000, 0, 0, 0, 0));
        send_sample(sample(200000, -100000, 1, -100, 1, 1, 1));  // steepest rises
        send_sample(sample(-100000, 200000, 1, 200, 1, 1, 1));
        send_sample(sample(-100001, -100000, 1, 0, 0, 0, 0));    // steepest fall
        send_sample(sample(262143, -262144, 65535, 255, 1, 0, 1));
        send_sample(sample(-262144, 262143, 65535, -256, 0, 1, 1));
        send_sample(sample(-262144, -262144, 1, -256, 1, 1, 0));
    endtask

    // Walks through several register settings, the extremes among them.
    task automatic test_config_sweep();
        t_cfg plan [8];
        longint scale;
        plan[0] = make_settings(1, 65000, 55000, 60000, 35000, 50, 4000, 0);
        plan[1] = make_settings(0, -100000, 200000, -100000, -100000, 200, 0, 0);
        plan[2] = make_settings(0, 200000, -100000, 200000, 200000, -100, 300000000, 0);
        plan[3] = make_settings(0, 65, 55, 60, 35, 50, 4, 1);
        plan[4] = make_settings(1, -100000, 200000, -100000, -100000, -100, 0, 1);
        for (int k = 5; k < 7; k++) begin
            scale = $urandom_range(1) ? 1000 : 1;
            plan[k] = make_settings(scale == 1000, longint'($urandom_range(40, 90)) * scale,
                                    longint'($urandom_range(20, 70)) * scale,
                                    longint'($urandom_range(30, 80)) * scale,
                                    longint'($urandom_range(20, 60)) * scale,
                                    longint'($urandom_range(300)) - 100,
                                    longint'($urandom_range(10)) * scale, 0);
        end
        plan[7] = reset_settings();
        for (int k = 0; k < 8; k++) begin
            apply_settings(plan[k]);
            select_idling(k);
            send_random(28);
        end
    endtask

    task automatic test_idle_phases();
        for (int phase = 0; phase < 4; phase++) begin
            select_idling(phase);
            send_random(35);
        end
    endtask

    // The receiver holds off long enough for the block to fill and stall its input while
    // words keep coming; afterwards the sender waits for everything to drain.
    task automatic test_backpressure();
        select_idling(0);
        wait_for_drain();
        out_hold_cycles = HOLD_CYCLES;
        send_random(12);
        wait_for_drain();
        select_idling(3);
        send_random(8);
    endtask

    initial begin
        shadow_cfg  = reset_settings();
        seeded_flag = 1'b0;
        trip_state  = 1'b0;
        alarm_state = 1'b0;
        for (int i = 0; i < 2; i++) begin
            prior_temp[i] = '0;
            rise_rate[i]  = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_sweep();
        test_idle_phases();
        test_backpressure();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
